@@ design/pgep_pkg.sv @@
// Shared types, register codes and constants of the pulse shape evaluator.
`default_nettype none

package pgep_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENT_BOUNDS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_AMPLITUDE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_CENTER     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_CURVATURE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_AMPLITUDE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_CENTER    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_CURVATURE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL_SETTINGS    = 3'd7;

   localparam logic [31:0] SEGMENT_BOUNDS_RESET   = 32'd1413894245;
   localparam logic [15:0] FIRST_AMPLITUDE_RESET  = 16'hE792;
   localparam logic [15:0] FIRST_CENTER_RESET     = 16'd20718;
   localparam logic [15:0] FIRST_CURVATURE_RESET  = 16'd5399;
   localparam logic [15:0] SECOND_AMPLITUDE_RESET = 16'hE591;
   localparam logic [15:0] SECOND_CENTER_RESET    = 16'd21027;
   localparam logic [15:0] SECOND_CURVATURE_RESET = 16'd1812;
   localparam logic [31:0] TAIL_SETTINGS_RESET    = 32'd430041193;

   localparam logic [1:0] SEG_FIRST  = 2'd0;
   localparam logic [1:0] SEG_SECOND = 2'd1;
   localparam logic [1:0] SEG_TAIL   = 2'd2;

   localparam int          SERIES_TERMS = 30;
   localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
   localparam logic [63:0] HALF_Q30     = 64'd1 << 29;

   typedef struct packed {
      logic [31:0] segment_bounds;
      logic [15:0] first_amplitude;
      logic [15:0] first_center;
      logic [15:0] first_curvature;
      logic [15:0] second_amplitude;
      logic [15:0] second_center;
      logic [15:0] second_curvature;
      logic [31:0] tail_settings;
   } cfg_type;

endpackage

`default_nettype wire

@@ design/pgep_csr.sv @@
// Configuration register file with write decode and template reset values.
`default_nettype none

module pgep_csr
   import pgep_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SEGMENT_BOUNDS:   cfg_in.segment_bounds   = csr_wdata;
            REG_FIRST_AMPLITUDE:  cfg_in.first_amplitude  = csr_wdata[15:0];
            REG_FIRST_CENTER:     cfg_in.first_center     = csr_wdata[15:0];
            REG_FIRST_CURVATURE:  cfg_in.first_curvature  = csr_wdata[15:0];
            REG_SECOND_AMPLITUDE: cfg_in.second_amplitude = csr_wdata[15:0];
            REG_SECOND_CENTER:    cfg_in.second_center    = csr_wdata[15:0];
            REG_SECOND_CURVATURE: cfg_in.second_curvature = csr_wdata[15:0];
            REG_TAIL_SETTINGS:    cfg_in.tail_settings    = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.segment_bounds   <= SEGMENT_BOUNDS_RESET;
         cfg_ff.first_amplitude  <= FIRST_AMPLITUDE_RESET;
         cfg_ff.first_center     <= FIRST_CENTER_RESET;
         cfg_ff.first_curvature  <= FIRST_CURVATURE_RESET;
         cfg_ff.second_amplitude <= SECOND_AMPLITUDE_RESET;
         cfg_ff.second_center    <= SECOND_CENTER_RESET;
         cfg_ff.second_curvature <= SECOND_CURVATURE_RESET;
         cfg_ff.tail_settings    <= TAIL_SETTINGS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ design/piecewise_gauss_exp_pulse_shape.sv @@
// Piecewise Gaussian / exponential pulse template evaluator, top level.
//
// One sample time enters per clock and one voltage leaves per clock while the
// output is not stalled; each item passes through a ten-stage pipeline (two
// multiplies for the exponent argument, a table lookup, the cubic correction and
// two rounding multiplies). A stall on the result side holds the pipeline stage
// by stage and empty stages still fill. The fractional exponential table is a
// constant ROM of EXP_TABLE_ENTRIES words, which must be a power of two from 16
// to 4096. Configuration registers take effect for items accepted after the
// write.
`default_nettype none

module piecewise_gauss_exp_pulse_shape
   import pgep_pkg::*;
#(
   parameter int EXP_TABLE_ENTRIES = 256
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // item in: [15:0] sample_time
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [15:0]            req_tdata,
   // item out: [15:0] voltage
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [15:0]            rsp_tdata,
   // item out: [1:0] segment
   output      logic [1:0]             rsp_tuser,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W      = $clog2(EXP_TABLE_ENTRIES);
   localparam int RHO_W      = 30 - IDX_W;
   localparam int RHO2_W     = 2 * RHO_W - 30;
   localparam int RHO3_W     = (3 * RHO_W > 60) ? 3 * RHO_W - 60 : 1;
   localparam int DIV6_SHIFT = RHO3_W + 3;
   localparam int D6_W       = RHO3_W + DIV6_SHIFT;
   localparam logic [63:0] DIV6_MUL = ((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6;
   localparam int STAGES     = 10;

   typedef logic [30:0] frac_tab_type [EXP_TABLE_ENTRIES];
   typedef logic [30:0] whole_tab_type [16];

   // shift-and-subtract quotient by a small count
   function automatic logic [63:0] div_count(input logic [63:0] x, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], x[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [30:0] exp_series(input logic [63:0] num);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rnd;
      term = 64'd1 << 40;
      sum  = $signed(term);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = div_count((term * num) >> IDX_W, 64'(n));
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      rnd = ($unsigned(sum) + (64'd1 << 9)) >> 10;
      return rnd[30:0];
   endfunction

   function automatic frac_tab_type build_frac();
      frac_tab_type tab;
      for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
         tab[i] = exp_series(64'(i));
      end
      return tab;
   endfunction

   function automatic whole_tab_type build_whole();
      whole_tab_type tab;
      logic [63:0]   e1;
      logic [63:0]   w;
      e1     = 64'(exp_series(64'(EXP_TABLE_ENTRIES)));
      w      = ONE_Q30;
      tab[0] = w[30:0];
      for (int i = 1; i < 16; i++) begin
         w      = (w * e1 + HALF_Q30) >> 30;
         tab[i] = w[30:0];
      end
      return tab;
   endfunction

   localparam frac_tab_type  FRAC_EXP  = build_frac();
   localparam whole_tab_type WHOLE_EXP = build_whole();

   cfg_type cfg;

   pgep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake and valid chain
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_tready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int s = 1; s < STAGES; s++) begin
            if (adv[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[STAGES-1];

   // carried payload
   logic [1:0]        seg_ff  [0:9];
   logic              neg_ff  [0:8];
   logic [15:0]       mag_ff  [0:7];
   logic              zero_ff [3:6];
   logic [30:0]       e_ff    [4:6];
   logic [RHO_W-1:0]  rho_ff  [3:4];
   logic [RHO2_W-1:0] rho2_ff [3:4];

   // stage 0: segment select and operand choice
   logic [1:0]  seg_in;
   logic [15:0] amp_sel;
   logic [15:0] center_sel;
   logic [15:0] ma_in, mb_in, curv_in;
   logic        tail_in;
   logic [15:0] t_val, b1, b2;

   always_comb begin
      t_val      = req_tdata[15:0];
      b1         = cfg.segment_bounds[15:0];
      b2         = cfg.segment_bounds[31:16];
      seg_in     = SEG_TAIL;
      amp_sel    = cfg.tail_settings[15:0];
      center_sel = '0;
      curv_in    = '0;
      tail_in    = 1'b1;
      ma_in      = t_val - b2;
      mb_in      = cfg.tail_settings[31:16];
      if (t_val <= b1) begin
         seg_in     = SEG_FIRST;
         amp_sel    = cfg.first_amplitude;
         center_sel = cfg.first_center;
         curv_in    = cfg.first_curvature;
         tail_in    = 1'b0;
      end else if (t_val <= b2) begin
         seg_in     = SEG_SECOND;
         amp_sel    = cfg.second_amplitude;
         center_sel = cfg.second_center;
         curv_in    = cfg.second_curvature;
         tail_in    = 1'b0;
      end
      if (!tail_in) begin
         ma_in = (t_val >= center_sel) ? t_val - center_sel : center_sel - t_val;
         mb_in = ma_in;
      end
   end

   logic [15:0] ma_ff, mb_ff;
   logic [15:0] curv0_ff, curv1_ff;
   logic        tail0_ff, tail1_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
         curv0_ff  <= curv_in;
         tail0_ff  <= tail_in;
      end
   end

   // stage 1: first product
   logic [31:0] p1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         p1_ff    <= 32'(ma_ff) * 32'(mb_ff);
         curv1_ff <= curv0_ff;
         tail1_ff <= tail0_ff;
      end
   end

   // stage 2: exponent argument, unsigned Q.32
   logic [47:0] u_in, u_ff;

   assign u_in = tail1_ff ? {8'd0, p1_ff, 8'd0} : 48'(p1_ff) * 48'(curv1_ff);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         u_ff <= u_in;
      end
   end

   // stage 3: table lookup and rho squared
   logic [RHO_W-1:0]   rho_in;
   logic [2*RHO_W-1:0] rho_sq;
   logic [30:0]        whole_ff, frac_ff;

   assign rho_in = u_ff[31-IDX_W:2];
   assign rho_sq = (2*RHO_W)'(rho_in) * (2*RHO_W)'(rho_in);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         zero_ff[3] <= |u_ff[47:36];
         whole_ff   <= WHOLE_EXP[u_ff[35:32]];
         frac_ff    <= FRAC_EXP[u_ff[31 -: IDX_W]];
         rho_ff[3]  <= rho_in;
         rho2_ff[3] <= rho_sq[2*RHO_W-1:30];
      end
   end

   // stage 4: table product and rho cubed
   logic [61:0]               e_prod;
   logic [30:0]               e_in;
   logic [RHO2_W+RHO_W-1:0]   r3_prod;
   logic [RHO3_W-1:0]         rho3_in, rho3_ff;

   assign e_prod  = 62'(whole_ff) * 62'(frac_ff) + 62'(HALF_Q30);
   assign e_in    = 31'(e_prod >> 30);
   assign r3_prod = (RHO2_W+RHO_W)'(rho2_ff[3]) * (RHO2_W+RHO_W)'(rho_ff[3]);
   assign rho3_in = RHO3_W'(r3_prod >> 30);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         e_ff[4]    <= e_in;
         rho3_ff    <= rho3_in;
         rho_ff[4]  <= rho_ff[3];
         rho2_ff[4] <= rho2_ff[3];
         zero_ff[4] <= zero_ff[3];
      end
   end

   // stage 5: cube over six and partial polynomial
   logic [D6_W-1:0]   d6_prod;
   logic [RHO3_W-1:0] div6_ff;
   logic [30:0]       part_in, part_ff;

   assign d6_prod = D6_W'(rho3_ff) * D6_W'(DIV6_MUL);
   assign part_in = 31'(ONE_Q30) - 31'(rho_ff[4]) + 31'(rho2_ff[4] >> 1);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         div6_ff    <= RHO3_W'(d6_prod >> DIV6_SHIFT);
         part_ff    <= part_in;
         e_ff[5]    <= e_ff[4];
         zero_ff[5] <= zero_ff[4];
      end
   end

   // stage 6: polynomial
   logic [30:0] poly_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         poly_ff    <= part_ff - 31'(div6_ff);
         e_ff[6]    <= e_ff[5];
         zero_ff[6] <= zero_ff[5];
      end
   end

   // stage 7: exponential factor, Q.30
   logic [61:0] f_prod;
   logic [30:0] f_in, f_ff;

   assign f_prod = 62'(e_ff[6]) * 62'(poly_ff) + 62'(HALF_Q30);
   assign f_in   = zero_ff[6] ? '0 : 31'(f_prod >> 30);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         f_ff <= f_in;
      end
   end

   // stage 8: amplitude scaling
   logic [47:0] m_prod;
   logic [17:0] m_ff;

   assign m_prod = 48'(mag_ff[7]) * 48'(f_ff) + 48'(HALF_Q30);

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         m_ff <= 18'(m_prod >> 30);
      end
   end

   // stage 9: saturate and apply sign
   logic [17:0] m_clip;
   logic [15:0] volt_in, volt_ff;

   always_comb begin
      if (neg_ff[8]) begin
         m_clip  = (m_ff > 18'd32768) ? 18'd32768 : m_ff;
         volt_in = 16'd0 - m_clip[15:0];
      end else begin
         m_clip  = (m_ff > 18'd32767) ? 18'd32767 : m_ff;
         volt_in = m_clip[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         volt_ff <= volt_in;
      end
   end

   // carry sign, magnitude and segment alongside
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         seg_ff[0] <= seg_in;
         neg_ff[0] <= amp_sel[15];
         mag_ff[0] <= amp_sel[15] ? 16'd0 - amp_sel : amp_sel;
      end
      for (int s = 1; s < STAGES; s++) begin
         if (adv[s]) begin
            seg_ff[s] <= seg_ff[s-1];
         end
      end
      for (int s = 1; s <= 8; s++) begin
         if (adv[s]) begin
            neg_ff[s] <= neg_ff[s-1];
         end
      end
      for (int s = 1; s <= 7; s++) begin
         if (adv[s]) begin
            mag_ff[s] <= mag_ff[s-1];
         end
      end
   end

   assign rsp_tdata = volt_ff;
   assign rsp_tuser = seg_ff[9];

endmodule

`default_nettype wire

@@ bench/pgep_shape_checker.sv @@
// Watches the pulse shape evaluator channels, predicts each sample and compares results.
`default_nettype none

module pgep_shape_checker
   import pgep_pkg::*;
#(
   parameter int EXP_TABLE_ENTRIES = 256
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // item in: [15:0] sample_time
   input  wire logic [15:0]            req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // item out: [15:0] voltage
   input  wire logic [15:0]            rsp_tdata,
   // item out: [1:0] segment
   input  wire logic [1:0]             rsp_tuser,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output      int                     pending,
   output      int                     fail_count
);

   typedef struct packed {
      logic [15:0] voltage;
      logic [1:0]  segment;
   } shape_sample_type;

   localparam logic [63:0] TABLE_N   = 64'(EXP_TABLE_ENTRIES);
   localparam logic [63:0] ARG_LIMIT = 64'd16 << 32;

   logic [63:0]      frac_rom [EXP_TABLE_ENTRIES];
   logic [63:0]      whole_rom [16];
   cfg_type          shape_cfg;
   shape_sample_type sample_q [$];
   shape_sample_type want;
   int               mismatches = 0;

   // e^-(num/den) by alternating series in Q.40, rounded to Q.30
   function automatic logic [63:0] series_exp(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] term;
      longint      acc;
      term = 64'd1 << 40;
      acc  = $signed(term);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = (term * num) / (den * 64'(n));
         if (n % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return ($unsigned(acc) + (64'd1 << 9)) >> 10;
   endfunction

   initial begin
      logic [63:0] e1;
      for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
         frac_rom[i] = series_exp(64'(i), TABLE_N);
      end
      e1 = series_exp(64'd1, 64'd1);
      whole_rom[0] = ONE_Q30;
      for (int i = 1; i < 16; i++) begin
         whole_rom[i] = (whole_rom[i-1] * e1 + HALF_Q30) >> 30;
      end
   end

   // e^-u, u unsigned Q.32, result Q.30
   function automatic logic [63:0] decay_q30(input logic [63:0] u);
      logic [63:0] fu, k, frac, scaled, idx, rho, rho2, rho3, poly, e;
      if (u >= ARG_LIMIT) begin
         return 64'd0;
      end
      fu     = u >> 2;
      k      = (fu >> 30) & 64'd15;
      frac   = fu & (ONE_Q30 - 64'd1);
      scaled = frac * TABLE_N;
      idx    = scaled >> 30;
      if (idx >= TABLE_N) begin
         idx = TABLE_N - 64'd1;
      end
      rho  = (scaled - (idx << 30)) / TABLE_N;
      rho2 = (rho * rho) >> 30;
      rho3 = (rho2 * rho) >> 30;
      poly = ONE_Q30 - rho + rho2 / 64'd2 - rho3 / 64'd6;
      e    = (whole_rom[k] * frac_rom[idx] + HALF_Q30) >> 30;
      return (e * poly + HALF_Q30) >> 30;
   endfunction

   function automatic logic [15:0] scale_voltage(input logic [15:0] amp, input logic [63:0] e);
      logic [63:0] mag, m;
      mag = amp[15] ? (64'd65536 - 64'(amp)) : 64'(amp);
      m   = (mag * e + HALF_Q30) >> 30;
      if (amp[15]) begin
         if (m > 64'd32768) begin
            m = 64'd32768;
         end
         return 16'(~m + 64'd1);
      end
      if (m > 64'd32767) begin
         m = 64'd32767;
      end
      return 16'(m);
   endfunction

   function automatic logic [63:0] gauss_arg(input logic [15:0] t, input logic [15:0] center,
                                             input logic [15:0] curv);
      logic [63:0] d;
      d = (t >= center) ? 64'(t - center) : 64'(center - t);
      return d * d * 64'(curv);
   endfunction

   function automatic shape_sample_type shape_at(input logic [15:0] t, input cfg_type c);
      shape_sample_type r;
      logic [15:0]      b1, b2;
      logic [63:0]      u;
      b1 = c.segment_bounds[15:0];
      b2 = c.segment_bounds[31:16];
      if (t <= b1) begin
         r.segment = SEG_FIRST;
         r.voltage = scale_voltage(c.first_amplitude,
                        decay_q30(gauss_arg(t, c.first_center, c.first_curvature)));
      end else if (t <= b2) begin
         r.segment = SEG_SECOND;
         r.voltage = scale_voltage(c.second_amplitude,
                        decay_q30(gauss_arg(t, c.second_center, c.second_curvature)));
      end else begin
         r.segment = SEG_TAIL;
         u = (64'(t - b2) * 64'(c.tail_settings[31:16])) << 8;
         r.voltage = scale_voltage(c.tail_settings[15:0], decay_q30(u));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shape_cfg = '{segment_bounds: SEGMENT_BOUNDS_RESET,
                       first_amplitude: FIRST_AMPLITUDE_RESET,
                       first_center: FIRST_CENTER_RESET,
                       first_curvature: FIRST_CURVATURE_RESET,
                       second_amplitude: SECOND_AMPLITUDE_RESET,
                       second_center: SECOND_CENTER_RESET,
                       second_curvature: SECOND_CURVATURE_RESET,
                       tail_settings: TAIL_SETTINGS_RESET};
         sample_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            sample_q.push_back(shape_at(req_tdata, shape_cfg));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sample_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: voltage %0d segment %0d",
                           $signed(rsp_tdata), rsp_tuser);
               end
            end else begin
               want = sample_q.pop_front();
               if (rsp_tdata !== want.voltage || rsp_tuser !== want.segment) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected voltage %0d segment %0d, got %0d %0d",
                              $signed(want.voltage), want.segment,
                              $signed(rsp_tdata), rsp_tuser);
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_SEGMENT_BOUNDS:   shape_cfg.segment_bounds   = csr_wdata[31:0];
               REG_FIRST_AMPLITUDE:  shape_cfg.first_amplitude  = csr_wdata[15:0];
               REG_FIRST_CENTER:     shape_cfg.first_center     = csr_wdata[15:0];
               REG_FIRST_CURVATURE:  shape_cfg.first_curvature  = csr_wdata[15:0];
               REG_SECOND_AMPLITUDE: shape_cfg.second_amplitude = csr_wdata[15:0];
               REG_SECOND_CENTER:    shape_cfg.second_center    = csr_wdata[15:0];
               REG_SECOND_CURVATURE: shape_cfg.second_curvature = csr_wdata[15:0];
               REG_TAIL_SETTINGS:    shape_cfg.tail_settings    = csr_wdata[31:0];
               default: ;
            endcase
         end
      end
      pending    <= sample_q.size();
      fail_count <= mismatches;
   end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Stimulus and verdict for the pulse shape evaluator, checked by pgep_shape_checker.
`default_nettype none

module tb;
   import pgep_pkg::*;

   localparam int TABLE_ENTRIES = 256;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 60;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [15:0]            req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [15:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     pending;
   int                     fail_count;
   int                     cycles = 0;
   int                     sent = 0;
   int                     taken = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   piecewise_gauss_exp_pulse_shape #(.EXP_TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pgep_shape_checker #(.EXP_TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .fail_count(fail_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // every third stretch of 40 items runs with no idling
   function automatic int idle_cycles(input int n);
      return ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 3));
         1: return 16'($urandom_range(0, 15));
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type     c;
      logic [15:0] b1, b2, swap;
      b1 = 16'($urandom);
      b2 = 16'($urandom);
      if (b1 > b2 && $urandom_range(0, 4) != 0) begin
         swap = b1;
         b1   = b2;
         b2   = swap;
      end
      c.segment_bounds   = {b2, b1};
      c.first_amplitude  = 16'($urandom);
      c.first_center     = 16'($urandom);
      c.first_curvature  = pick_scale();
      c.second_amplitude = 16'($urandom);
      c.second_center    = 16'($urandom);
      c.second_curvature = pick_scale();
      c.tail_settings    = {pick_scale(), 16'($urandom)};
      return c;
   endfunction

   function automatic logic [15:0] pick_time(input cfg_type c);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom);
         4, 5: return c.first_center + 16'($urandom_range(0, 1023)) - 16'd512;
         6: return c.second_center + 16'($urandom_range(0, 1023)) - 16'd512;
         7: return c.segment_bounds[15:0] + 16'($urandom_range(0, 16)) - 16'd8;
         8: return c.segment_bounds[31:16] + 16'($urandom_range(0, 16)) - 16'd8;
         default: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // upper bits of the 16-bit registers carry junk that must be dropped
   task automatic write_settings(input cfg_type c);
      logic [15:0] junk;
      junk = 16'($urandom);
      csr_write(REG_SEGMENT_BOUNDS, c.segment_bounds);
      csr_write(REG_FIRST_AMPLITUDE, {junk, c.first_amplitude});
      csr_write(REG_FIRST_CENTER, {~junk, c.first_center});
      csr_write(REG_FIRST_CURVATURE, {junk, c.first_curvature});
      csr_write(REG_SECOND_AMPLITUDE, {~junk, c.second_amplitude});
      csr_write(REG_SECOND_CENTER, {junk, c.second_center});
      csr_write(REG_SECOND_CURVATURE, {~junk, c.second_curvature});
      csr_write(REG_TAIL_SETTINGS, c.tail_settings);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input logic [15:0] t);
      int gap;
      gap = idle_cycles(sent);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_cycles(taken);
         if (taken == 100 || taken == 300) begin
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      cfg_type     reset_cfg, edge_cfg, reversed_cfg, cur_cfg;
      logic [15:0] b1, b2;
      logic [15:0] probes [$];
      reset_cfg = '{segment_bounds: SEGMENT_BOUNDS_RESET,
                    first_amplitude: FIRST_AMPLITUDE_RESET,
                    first_center: FIRST_CENTER_RESET,
                    first_curvature: FIRST_CURVATURE_RESET,
                    second_amplitude: SECOND_AMPLITUDE_RESET,
                    second_center: SECOND_CENTER_RESET,
                    second_curvature: SECOND_CURVATURE_RESET,
                    tail_settings: TAIL_SETTINGS_RESET};
      edge_cfg = '{segment_bounds: 32'hC000_4000,
                   first_amplitude: 16'h7FFF, first_center: 16'h2000,
                   first_curvature: 16'h0000,
                   second_amplitude: 16'h8000, second_center: 16'h8000,
                   second_curvature: 16'hFFFF,
                   tail_settings: 32'hFFFF_7FFF};
      reversed_cfg = '{segment_bounds: 32'h1000_A000,
                       first_amplitude: 16'h0000, first_center: 16'hFFFF,
                       first_curvature: 16'h0001,
                       second_amplitude: 16'h7FFF, second_center: 16'h0000,
                       second_curvature: 16'h0000,
                       tail_settings: 32'h0000_8000};
      req_tvalid <= 1'b0;
      req_tdata  <= 16'd0;
      csr_we     <= 1'b0;
      csr_index  <= REG_SEGMENT_BOUNDS;
      csr_wdata  <= 32'd0;
      reset      <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      b1 = SEGMENT_BOUNDS_RESET[15:0];
      b2 = SEGMENT_BOUNDS_RESET[31:16];
      probes = {16'h0000, 16'h0001, b1, b1 + 16'd1, b2, b2 + 16'd1,
                FIRST_CENTER_RESET, SECOND_CENTER_RESET, 16'h7FFF, 16'h8000, 16'hFFFF};
      foreach (probes[i]) send_sample(probes[i]);
      drain();

      // zero curvature gives the bare amplitude; steep ones push the argument past the limit
      write_settings(edge_cfg);
      probes = {16'h2000, 16'h4000, 16'h4001, 16'h8000, 16'h8001, 16'h9000,
                16'hC000, 16'hC001, 16'hFFFF};
      foreach (probes[i]) send_sample(probes[i]);
      drain();

      // reversed boundaries: the second Gaussian never wins
      write_settings(reversed_cfg);
      probes = {16'h0000, 16'h1000, 16'h1001, 16'hA000, 16'hA001, 16'hFFFF};
      foreach (probes[i]) send_sample(probes[i]);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cur_cfg = (p == RANDOM_PHASES - 1) ? reset_cfg : random_cfg();
         write_settings(cur_cfg);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(pick_time(cur_cfg));
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
design/pgep_pkg.sv
design/pgep_csr.sv
design/piecewise_gauss_exp_pulse_shape.sv
bench/pgep_shape_checker.sv
bench/tb.sv
